### design/spp_pkg.sv
package spp_pkg;

  // Field widths of the point and peak words
  localparam int unsigned MZ_W     = 32;
  localparam int unsigned LEVEL_W  = 32;
  localparam int unsigned INDEX_W  = 16;
  localparam int unsigned SPACE_W  = 31;

  // Default spectrum length limit
  localparam int unsigned MAX_POINTS_DEF = 65536;

  // Result queue depth; two slots must be free to take a point
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MZ_SPACING      = 1'b0,
    REG_LEVEL_THRESHOLD = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [INDEX_W-1:0] peak_pos;
    logic [MZ_W-1:0]    peak_mz;
    logic [LEVEL_W-1:0] peak_level;
    logic               run_end;
  } peak_word_t;

  // Gap from lo to hi exceeds twice the spacing; a negative gap never does
  function automatic logic gap_wide(input logic [MZ_W-1:0] hi, input logic [MZ_W-1:0] lo,
                                    input logic [SPACE_W-1:0] spacing);
    logic [MZ_W+1:0] diff;
    logic [MZ_W:0]   lim;
    diff = {2'b00, hi} - {2'b00, lo};
    lim  = {1'b0, spacing, 1'b0};
    return !diff[MZ_W+1] && (diff[MZ_W:0] > lim);
  endfunction

endpackage

### design/spp_in_if.sv
interface spp_in_if;
  logic                         valid;
  logic                         ready;
  logic [spp_pkg::MZ_W-1:0]     mz_value;
  logic [spp_pkg::LEVEL_W-1:0]  level;
  logic                         final_point;

  modport source (output valid, output mz_value, output level, output final_point,
                  input ready);
  modport sink (input valid, input mz_value, input level, input final_point,
                output ready);
endinterface

### design/spp_out_if.sv
interface spp_out_if;
  logic                         valid;
  logic                         ready;
  logic [spp_pkg::INDEX_W-1:0]  peak_pos;
  logic [spp_pkg::MZ_W-1:0]     peak_mz;
  logic [spp_pkg::LEVEL_W-1:0]  peak_level;
  logic                         run_end;

  modport source (output valid, output peak_pos, output peak_mz, output peak_level,
                  output run_end, input ready);
  modport sink (input valid, input peak_pos, input peak_mz, input peak_level,
                input run_end, output ready);
endinterface

### design/spectrum_peak_picker.sv
// Streaming local-maximum peak picker.
// in_pt carries one spectrum point per word (m/z Q16.16, intensity, last-point
// flag), in ascending m/z. out_pk carries one word per peak found, in index
// order; run_end marks the last peak word caused by one input point.
// Configuration (cfg_wr_en/cfg_index/cfg_wr_data) sets the m/z spacing and
// the intensity threshold; write it only while no spectrum is in flight.
// Throughput: one point per cycle while two queue slots are free. Each point is judged
// in the cycle it is accepted and its zero, one or two peak words enter a
// four-word result queue; a peak word can leave on out_pk in the cycle after
// its point was taken. A point is accepted whenever at least two queue slots
// are free, so both peak words of a point always find room. With a stalled
// receiver the queue backs up, and in_pt.ready stays low while fewer than two
// slots are free; nothing is lost. Synchronous reset (rst_n low) clears the
// point history, the point counter, the queue and both registers.
// Point counts saturate at MAX_POINTS; reported indices cap at MAX_POINTS-1.
module spectrum_peak_picker #(
  parameter int unsigned MAX_POINTS = spp_pkg::MAX_POINTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [spp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [spp_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
  spp_in_if.sink                            in_pt,
  spp_out_if.source                         out_pk
);

  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned IDX_EXT_W = (CNT_W > spp_pkg::INDEX_W) ? CNT_W : spp_pkg::INDEX_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);
  localparam logic [CNT_W-1:0] IDX_MAX = CNT_W'(MAX_POINTS - 1);
  localparam logic [spp_pkg::QCNT_W-1:0] QCNT_TAKE =
    spp_pkg::QCNT_W'(spp_pkg::QUEUE_DEPTH - 2);
  localparam logic [spp_pkg::QCNT_W-1:0] QCNT_FULL =
    spp_pkg::QCNT_W'(spp_pkg::QUEUE_DEPTH);

  // Configuration registers
  logic [spp_pkg::SPACE_W-1:0] mz_spacing_r;
  logic [spp_pkg::LEVEL_W-1:0] level_threshold_r;

  // Point history
  logic [spp_pkg::MZ_W-1:0]    older_mz_r, newer_mz_r;
  logic [spp_pkg::LEVEL_W-1:0] older_level_r, newer_level_r;
  logic [CNT_W-1:0]            pt_cnt_r;

  // Result queue
  spp_pkg::peak_word_t          q_mem_r [spp_pkg::QUEUE_DEPTH];
  logic [spp_pkg::QPTR_W-1:0]   q_wptr_r, q_rptr_r;
  logic [spp_pkg::QCNT_W-1:0]   q_cnt_r;

  logic in_fire, out_fire;
  logic cnt_zero, cnt_one;
  logic wide_next, wide_prev, local_max, isolated;
  logic hit0, hit1;
  logic [CNT_W-1:0] mid_idx, last_idx;
  spp_pkg::peak_word_t word0, word1;
  logic [1:0] n_push;

  function automatic logic [spp_pkg::INDEX_W-1:0] cap_idx(input logic [CNT_W-1:0] idx);
    logic [IDX_EXT_W-1:0] ext;
    ext = IDX_EXT_W'((idx > IDX_MAX) ? IDX_MAX : idx);
    return ext[spp_pkg::INDEX_W-1:0];
  endfunction

  assign in_pt.ready  = (q_cnt_r <= QCNT_TAKE);
  assign in_fire      = in_pt.valid && in_pt.ready;
  assign out_pk.valid = (q_cnt_r != '0);
  assign out_fire     = out_pk.valid && out_pk.ready;

  // Judge the window formed by the two held points and the incoming one
  always_comb begin
    cnt_zero  = (pt_cnt_r == '0);
    cnt_one   = (pt_cnt_r == CNT_W'(1));
    wide_next = spp_pkg::gap_wide(in_pt.mz_value, newer_mz_r, mz_spacing_r);
    wide_prev = spp_pkg::gap_wide(newer_mz_r, older_mz_r, mz_spacing_r);
    local_max = (newer_level_r >= older_level_r) && (newer_level_r > in_pt.level);
    isolated  = wide_prev && wide_next;
    mid_idx   = pt_cnt_r - CNT_W'(1);
    last_idx  = pt_cnt_r;

    // Previous point: first point or middle point
    priority if (cnt_zero) begin
      hit0 = 1'b0;
    end else if (cnt_one) begin
      hit0 = wide_next && (newer_level_r > level_threshold_r);
    end else begin
      hit0 = (local_max || isolated) && (newer_level_r > level_threshold_r);
    end

    // Incoming point: lone point or last point
    if (cnt_zero) begin
      hit1 = in_pt.final_point;
    end else begin
      hit1 = in_pt.final_point && wide_next && (in_pt.level > level_threshold_r);
    end

    word0.peak_pos   = cap_idx(mid_idx);
    word0.peak_mz    = newer_mz_r;
    word0.peak_level = newer_level_r;
    word0.run_end    = !hit1;

    word1.peak_pos   = cap_idx(last_idx);
    word1.peak_mz    = in_pt.mz_value;
    word1.peak_level = in_pt.level;
    word1.run_end    = 1'b1;

    n_push = in_fire ? ({1'b0, hit0} + {1'b0, hit1}) : 2'd0;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mz_spacing_r      <= '0;
      level_threshold_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (spp_pkg::cfg_reg_t'(cfg_index))
        spp_pkg::REG_MZ_SPACING:      mz_spacing_r      <= cfg_wr_data[spp_pkg::SPACE_W-1:0];
        spp_pkg::REG_LEVEL_THRESHOLD: level_threshold_r <= cfg_wr_data[spp_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the point history; clear it after the last point
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_mz_r    <= '0;
      older_level_r <= '0;
      newer_mz_r    <= '0;
      newer_level_r <= '0;
      pt_cnt_r      <= '0;
    end else if (in_fire) begin
      if (in_pt.final_point) begin
        older_mz_r    <= '0;
        older_level_r <= '0;
        newer_mz_r    <= '0;
        newer_level_r <= '0;
        pt_cnt_r      <= '0;
      end else begin
        older_mz_r    <= newer_mz_r;
        older_level_r <= newer_level_r;
        newer_mz_r    <= in_pt.mz_value;
        newer_level_r <= in_pt.level;
        if (pt_cnt_r < CNT_MAX) begin
          pt_cnt_r <= pt_cnt_r + CNT_W'(1);
        end
      end
    end
  end

  // Queue storage: the first hit takes the write slot, the second the next one
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (hit0) begin
        q_mem_r[q_wptr_r] <= word0;
        if (hit1) begin
          q_mem_r[q_wptr_r + spp_pkg::QPTR_W'(1)] <= word1;
        end
      end else if (hit1) begin
        q_mem_r[q_wptr_r] <= word1;
      end
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wptr_r <= '0;
      q_rptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      q_wptr_r <= q_wptr_r + spp_pkg::QPTR_W'(n_push);
      if (out_fire) begin
        q_rptr_r <= q_rptr_r + spp_pkg::QPTR_W'(1);
      end
      q_cnt_r <= q_cnt_r + spp_pkg::QCNT_W'(n_push) - spp_pkg::QCNT_W'(out_fire);
    end
  end

  // Drive the head word
  assign out_pk.peak_pos   = q_mem_r[q_rptr_r].peak_pos;
  assign out_pk.peak_mz    = q_mem_r[q_rptr_r].peak_mz;
  assign out_pk.peak_level = q_mem_r[q_rptr_r].peak_level;
  assign out_pk.run_end    = q_mem_r[q_rptr_r].run_end;

  // Queue never overflows
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= QCNT_FULL)
    else $error("result queue overflow");

  // Last point of a spectrum clears the counter
  a_final_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_pt.final_point |=> pt_cnt_r == '0)
    else $error("point counter not cleared after last point");

  // Non-final point advances the counter until saturation
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_pt.final_point && (pt_cnt_r < CNT_MAX) |=>
      pt_cnt_r == $past(pt_cnt_r) + CNT_W'(1))
    else $error("point counter did not advance");

  // Fill count holds when nothing is pushed or popped
  a_q_count: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire && !out_fire |=> $stable(q_cnt_r))
    else $error("queue count moved without traffic");

endmodule

### verif/tb_spectrum_peak_picker.sv
`timescale 1ns / 100ps

module tb_spectrum_peak_picker;

  localparam int unsigned MAX_PTS     = spp_pkg::MAX_POINTS_DEF;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam longint      MZ_TOP      = 64'h0000_0000_FFFF_FFFF;

  typedef struct {
    logic [spp_pkg::MZ_W-1:0]    mz;
    logic [spp_pkg::LEVEL_W-1:0] level;
    logic                        fin;
    logic                        hold_off;  // wait for all peaks to drain before sending
  } point_t;

  typedef enum logic [1:0] {
    TAKE_ALL,
    TAKE_HALF,
    TAKE_RARE
  } take_mode_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                           cfg_wr_en;
  logic [spp_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [spp_pkg::CFG_DATA_W-1:0] cfg_wr_data;

  spp_in_if  pt_chan ();
  spp_out_if pk_chan ();

  spectrum_peak_picker #(
    .MAX_POINTS (MAX_PTS)
  ) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .in_pt       (pt_chan),
    .out_pk      (pk_chan)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Points waiting to be sent and peak words waiting to come out
  point_t              points_due[$];
  spp_pkg::peak_word_t peaks_due[$];
  int unsigned bad_words = 0;

  // Picker state as seen by the prediction
  logic [spp_pkg::SPACE_W-1:0] spacing_q = '0;
  logic [spp_pkg::LEVEL_W-1:0] thresh_q  = '0;
  logic [spp_pkg::MZ_W-1:0]    hist_old_mz, hist_new_mz;
  logic [spp_pkg::LEVEL_W-1:0] hist_old_level, hist_new_level;
  int unsigned                 pts_seen;

  initial begin
    hist_old_mz    = '0;
    hist_new_mz    = '0;
    hist_old_level = '0;
    hist_new_level = '0;
    pts_seen       = 0;
  end

  // A gap breaks the run when it exceeds twice the spacing; backward gaps never do
  function automatic logic breaks_gap(logic [spp_pkg::MZ_W-1:0] hi,
                                      logic [spp_pkg::MZ_W-1:0] lo);
    return (longint'(hi) - longint'(lo)) > 2 * longint'(spacing_q);
  endfunction

  function automatic spp_pkg::peak_word_t make_peak(int unsigned idx,
                                                    logic [spp_pkg::MZ_W-1:0] mz,
                                                    logic [spp_pkg::LEVEL_W-1:0] lv);
    spp_pkg::peak_word_t w;
    w.peak_pos   = spp_pkg::INDEX_W'((idx > MAX_PTS - 1) ? MAX_PTS - 1 : idx);
    w.peak_mz    = mz;
    w.peak_level = lv;
    w.run_end    = 1'b0;
    return w;
  endfunction

  // Judge one accepted point: queue the peaks it settles, then shift the window
  task automatic judge_point(input point_t p);
    spp_pkg::peak_word_t found[$];
    logic                wide_right;
    logic                is_max;
    logic                lone;
    if (pts_seen == 0) begin
      if (p.fin) found.insert(found.size(), make_peak(0, p.mz, p.level));
    end else begin
      wide_right = breaks_gap(p.mz, hist_new_mz);
      if (pts_seen == 1) begin
        if (wide_right && hist_new_level > thresh_q)
          found.insert(found.size(), make_peak(0, hist_new_mz, hist_new_level));
      end else begin
        is_max = hist_new_level >= hist_old_level && hist_new_level > p.level;
        lone   = breaks_gap(hist_new_mz, hist_old_mz) && wide_right;
        if ((is_max || lone) && hist_new_level > thresh_q)
          found.insert(found.size(), make_peak(pts_seen - 1, hist_new_mz, hist_new_level));
      end
      if (p.fin && wide_right && p.level > thresh_q)
        found.insert(found.size(), make_peak(pts_seen, p.mz, p.level));
    end
    if (found.size() != 0) found[found.size() - 1].run_end = 1'b1;
    foreach (found[k]) peaks_due.insert(peaks_due.size(), found[k]);

    if (p.fin) begin
      hist_old_mz    = '0;
      hist_old_level = '0;
      hist_new_mz    = '0;
      hist_new_level = '0;
      pts_seen       = 0;
    end else begin
      hist_old_mz    = hist_new_mz;
      hist_old_level = hist_new_level;
      hist_new_mz    = p.mz;
      hist_new_level = p.level;
      if (pts_seen < MAX_PTS) pts_seen++;
    end
  endtask

  // Point driver: bursts of random length with random gaps
  point_t      shown;
  int unsigned gap_left   = 0;
  int unsigned burst_left = 0;

  always @(posedge clk) begin : point_driver
    logic go;
    if (!rst_n) begin
      pt_chan.valid       <= 1'b0;
      pt_chan.mz_value    <= '0;
      pt_chan.level       <= '0;
      pt_chan.final_point <= 1'b0;
    end else begin
      if (pt_chan.valid && pt_chan.ready) judge_point(shown);
      // advance only when nothing is held on the channel
      if (!pt_chan.valid || pt_chan.ready) begin
        go = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (points_due.size() != 0 &&
                     !(points_due[0].hold_off && peaks_due.size() != 0)) begin
          shown = points_due.pop_front();
          go    = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 10);
          end
        end
        pt_chan.valid <= go;
        if (go) begin
          pt_chan.mz_value    <= shown.mz;
          pt_chan.level       <= shown.level;
          pt_chan.final_point <= shown.fin;
        end
      end
    end
  end

  // Peak monitor: check each word, stall on a mode that changes now and then
  take_mode_t  take_mode = TAKE_ALL;
  int unsigned mode_left = 0;

  always @(posedge clk) begin : peak_monitor
    spp_pkg::peak_word_t want;
    if (!rst_n) begin
      pk_chan.ready <= 1'b0;
    end else begin
      if (pk_chan.valid && pk_chan.ready) begin
        if (peaks_due.size() == 0) begin
          $error("unexpected peak word: index %0d mz %h level %h",
                 pk_chan.peak_pos, pk_chan.peak_mz, pk_chan.peak_level);
          bad_words++;
        end else begin
          want = peaks_due.pop_front();
          if (pk_chan.peak_pos !== want.peak_pos) begin
            $error("peak_pos: expected %0d, got %0d", want.peak_pos, pk_chan.peak_pos);
            bad_words++;
          end
          if (pk_chan.peak_mz !== want.peak_mz) begin
            $error("peak_mz: expected %h, got %h", want.peak_mz, pk_chan.peak_mz);
            bad_words++;
          end
          if (pk_chan.peak_level !== want.peak_level) begin
            $error("peak_level: expected %h, got %h", want.peak_level, pk_chan.peak_level);
            bad_words++;
          end
          if (pk_chan.run_end !== want.run_end) begin
            $error("run_end: expected %0b, got %0b", want.run_end, pk_chan.run_end);
            bad_words++;
          end
        end
      end
      if (mode_left == 0) begin
        take_mode = take_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      case (take_mode)
        TAKE_ALL:  pk_chan.ready <= 1'b1;
        TAKE_HALF: pk_chan.ready <= 1'($urandom_range(0, 1));
        default:   pk_chan.ready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  // Watchdog: end the run when no word moves for too long
  int unsigned idle_cycles = 0;

  always @(posedge clk) begin : watchdog
    if (!rst_n || (pt_chan.valid && pt_chan.ready) || (pk_chan.valid && pk_chan.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("spectrum_peak_picker: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_point(logic [spp_pkg::MZ_W-1:0] mz, logic [spp_pkg::LEVEL_W-1:0] lv,
                             logic fin, logic hold);
    point_t p;
    p = '{mz, lv, fin, hold};
    points_due.insert(points_due.size(), p);
  endtask

  // Write both registers back to back; the picker must be idle
  task automatic set_config(logic [spp_pkg::CFG_DATA_W-1:0] spacing_word,
                            logic [spp_pkg::CFG_DATA_W-1:0] thresh_word);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= spp_pkg::REG_MZ_SPACING;
    cfg_wr_data <= spacing_word;
    @(posedge clk);
    cfg_index   <= spp_pkg::REG_LEVEL_THRESHOLD;
    cfg_wr_data <= thresh_word;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    spacing_q = spacing_word[spp_pkg::SPACE_W-1:0];
    thresh_q  = thresh_word;
    @(negedge clk);
  endtask

  // Hold until every point is sent and every peak word has come out
  task automatic wait_idle();
    do @(negedge clk);
    while (points_due.size() != 0 || pt_chan.valid || peaks_due.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic [spp_pkg::LEVEL_W-1:0] pick_level();
    case ($urandom_range(0, 3))
      0:       return $urandom();
      1:       return thresh_q + $urandom_range(0, 6) - 3;
      2:       return $urandom_range(0, 15);
      default: return thresh_q + $urandom_range(0, 2);
    endcase
  endfunction

  // Step to the next m/z: narrow, exactly at the break, just past it, random or backward
  function automatic logic [spp_pkg::MZ_W-1:0] pick_step();
    longint twice;
    twice = 2 * longint'(spacing_q);
    case ($urandom_range(0, 7))
      0, 1, 2: return $urandom_range(0, 32'(twice));
      3:       return 32'(twice);
      4, 5:    return (twice + 4 > MZ_TOP) ? 32'hFFFF_FFFF
                                           : 32'(twice + 1 + $urandom_range(0, 3));
      6:       return $urandom();
      default: return 32'd0 - $urandom_range(1, 64);
    endcase
  endfunction

  task automatic add_spectrum(input int unsigned len);
    logic [spp_pkg::MZ_W-1:0] mz;
    mz = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 1000);
    for (int unsigned k = 0; k < len; k++) begin
      queue_point(mz, pick_level(), k == len - 1, $urandom_range(0, 39) == 0);
      mz += pick_step();
    end
  endtask

  initial begin : stimulus
    int unsigned sent;
    int unsigned len;

    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_index   = spp_pkg::REG_MZ_SPACING;
    cfg_wr_data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: spacing 1.0, threshold 100
    set_config(32'h0001_0000, 32'd100);
    // single-point spectra skip the threshold
    queue_point(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0);
    queue_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
    // two points, wide gap: both ends come out with the second point
    queue_point(32'h0001_0000, 32'd500, 1'b0, 1'b0);
    queue_point(32'h0005_0000, 32'd600, 1'b1, 1'b1);
    // plateau: only the right end of the flat top is a maximum
    queue_point(32'h0010_0000, 32'd10, 1'b0, 1'b0);
    queue_point(32'h0011_0000, 32'd200, 1'b0, 1'b0);
    queue_point(32'h0012_0000, 32'd200, 1'b0, 1'b0);
    queue_point(32'h0013_0000, 32'd50, 1'b0, 1'b0);
    queue_point(32'h0013_1000, 32'd101, 1'b1, 1'b0);
    // isolated middle point below both neighbors
    queue_point(32'h0020_0000, 32'd300, 1'b0, 1'b0);
    queue_point(32'h0030_0000, 32'd150, 1'b0, 1'b0);
    queue_point(32'h0040_0000, 32'd400, 1'b0, 1'b0);
    queue_point(32'h0040_0100, 32'd100, 1'b1, 1'b0);
    // backward step is never a break
    queue_point(32'h0050_0000, 32'd100, 1'b0, 1'b0);
    queue_point(32'h0048_0000, 32'd120, 1'b0, 1'b0);
    queue_point(32'h0049_0000, 32'd100, 1'b1, 1'b0);
    // level equal to the threshold is not reported
    queue_point(32'h0060_0000, 32'd50, 1'b0, 1'b0);
    queue_point(32'h0070_0000, 32'd100, 1'b1, 1'b1);
    // full m/z span as one gap
    queue_point(32'h0000_0000, 32'd200, 1'b0, 1'b0);
    queue_point(32'hFFFF_FFFF, 32'd0, 1'b1, 1'b0);
    wait_idle();

    // Widest spacing (top data bit dropped) and highest threshold
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_point(32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0);
    queue_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
    queue_point(32'h0000_0007, 32'h0000_0000, 1'b1, 1'b0);
    wait_idle();

    // Random spectra under a range of settings
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       set_config(32'h0000_0000, 32'h0000_0000);
        1:       set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        2:       set_config(32'h0001_0000, $urandom_range(0, 2000));
        3:       set_config($urandom(), $urandom());
        default: set_config($urandom_range(0, 32'h0004_0000), $urandom_range(0, 32'h0010_0000));
      endcase
      sent = 0;
      while (sent < 70) begin
        case ($urandom_range(0, 7))
          0:       len = 1;
          1:       len = $urandom_range(20, 40);
          default: len = $urandom_range(2, 10);
        endcase
        add_spectrum(len);
        sent += len;
      end
      wait_idle();
    end

    if (bad_words == 0) begin
      $display("spectrum_peak_picker: match");
    end else begin
      $display("spectrum_peak_picker: mismatch");
    end
    $finish;
  end

endmodule
